/* rtl/core/assert_macros.svh */
// Assertion macros for the checker file of the receiver.
// Depends on nothing; the using module must provide clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define CHK_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent holds.
`define CHK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/igfr_pkg.sv */
// Shared types and constants of the idle-gap frame receiver.
// Depends on nothing; used by the front, queue, back end and top level.
`default_nettype none

package igfr_pkg;

	// Request kinds carried in s_tuser.
	localparam logic [1:0] OP_BYTE = 2'd0;
	localparam logic [1:0] OP_TICK = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	localparam logic [7:0] THR_RESET = 8'd10;
	localparam logic [7:0] TICKS_MAX = 8'hFF;

	// Wide enough for a byte count of the deepest supported buffer (64).
	localparam int MAX_CNT_W = 7;

	// Entries in the command queue between front and back end.
	localparam int Q_DEPTH = 2;

	// One read command handed from the front to the back end.
	typedef struct packed {
		logic                 is_frame;
		logic                 dropped;
		logic [MAX_CNT_W-1:0] count;
	} cmd_t;

endpackage

`default_nettype wire

/* rtl/core/idle_gap_frame_receiver_unit.sv */
// Idle-gap frame receiver. Byte, tick and ignored requests give no result. A read request goes
// through the command queue, RAM read and output registers, then gives one frame byte per cycle
// from the RAM's single read port unless stalled, or a zero result if no frame is ready; input
// is held off until a frame's last byte is read out. Reset is asynchronous and clears
// counts, flags and queues; the idle threshold returns to 10 and buffer contents are undefined.
`default_nettype none

module idle_gap_frame_receiver_unit
	import igfr_pkg::*;
#(
	parameter int BUFFER_DEPTH = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
	input  wire logic [1:0] s_tuser,   // [1:0] operation
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] frame_byte
	output logic [1:0]      m_tuser,   // [0] has_frame, [1] bytes_dropped
	output logic            m_tlast,   // last_byte
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata  // idle_threshold
);

	localparam int AW = $clog2(BUFFER_DEPTH);

	cmd_t          push_cmd;
	cmd_t          head_cmd;
	logic          q_push;
	logic          q_pop;
	logic          q_empty;
	logic          q_full;
	logic          frame_popped;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	igfr_front #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.q_full       (q_full),
		.frame_popped (frame_popped),
		.q_push       (q_push),
		.q_cmd        (push_cmd),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata)
	);

	igfr_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.head     (head_cmd),
		.empty    (q_empty),
		.full     (q_full)
	);

	igfr_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_buf (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	igfr_back #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_head       (head_cmd),
		.q_pop        (q_pop),
		.frame_popped (frame_popped),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.m_tlast      (m_tlast)
	);

endmodule

`default_nettype wire

/* rtl/core/igfr_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module igfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/core/igfr_front.sv */
// Front end: takes requests, keeps fill count, idle counter and frame flags,
// writes bytes into the buffer and queues read commands. Uses igfr_pkg.
`default_nettype none

module igfr_front
	import igfr_pkg::*;
#(
	parameter int BUFFER_DEPTH = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [7:0]                      s_tdata,
	input  wire logic [1:0]                      s_tuser,
	input  wire logic                            cfg_we,
	input  wire logic [7:0]                      cfg_wdata,
	input  wire logic                            q_full,
	input  wire logic                            frame_popped,
	output logic                                 q_push,
	output cmd_t                                 q_cmd,
	output logic                                 ram_we,
	output logic [$clog2(BUFFER_DEPTH)-1:0]      ram_waddr,
	output logic [7:0]                           ram_wdata
);

	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam int CW = $clog2(BUFFER_DEPTH + 1);

	logic [CW-1:0] fill_q;
	logic [7:0]    ticks_q;
	logic [7:0]    thr_q;
	logic          done_q;
	logic          ovf_q;
	logic          pend_q;
	logic          accept;
	logic          buf_full;
	logic          frame_ready;
	logic [7:0]    ticks_nx;

	// A queued frame locks the buffer until the back end has read it out.
	assign s_tready    = !pend_q && !q_full;
	assign accept      = s_tvalid && s_tready;
	assign buf_full    = (fill_q == CW'(BUFFER_DEPTH));
	assign frame_ready = done_q && (fill_q != '0);
	assign ticks_nx    = (ticks_q == TICKS_MAX) ? ticks_q : ticks_q + 8'd1;

	assign ram_we    = accept && (s_tuser == OP_BYTE) && !buf_full;
	assign ram_waddr = fill_q[AW-1:0];
	assign ram_wdata = s_tdata;

	assign q_push = accept && (s_tuser == OP_READ);
	always_comb begin
		q_cmd = '0;
		if (frame_ready) begin
			q_cmd.is_frame = 1'b1;
			q_cmd.dropped  = ovf_q;
			q_cmd.count    = MAX_CNT_W'(fill_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			ticks_q <= '0;
			done_q  <= 1'b0;
			ovf_q   <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			if (frame_popped) begin
				pend_q <= 1'b0;
			end
			if (accept) begin
				unique case (s_tuser)
					OP_BYTE: begin
						if (buf_full) begin
							ovf_q <= 1'b1;
						end else begin
							fill_q <= fill_q + CW'(1);
						end
						ticks_q <= '0;
					end
					OP_TICK: begin
						ticks_q <= ticks_nx;
						if ((fill_q != '0) && (ticks_nx >= thr_q)) begin
							done_q <= 1'b1;
						end
					end
					OP_READ: begin
						if (frame_ready) begin
							fill_q <= '0;
							done_q <= 1'b0;
							ovf_q  <= 1'b0;
							pend_q <= 1'b1;
						end
					end
					OP_NONE: begin
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/igfr_cmdq.sv */
// Short command queue between the front and the back end.
// Uses igfr_pkg for the command type and depth.
`default_nettype none

module igfr_cmdq
	import igfr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	input  wire logic pop,
	output cmd_t      head,
	output logic      empty,
	output logic      full
);

	localparam int PW = $clog2(Q_DEPTH);
	localparam int NW = $clog2(Q_DEPTH + 1);

	cmd_t          slot_q [Q_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] used_q;
	logic          do_push;
	logic          do_pop;

	assign empty   = (used_q == '0);
	assign full    = (used_q == NW'(Q_DEPTH));
	assign head    = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			used_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				used_q <= used_q + NW'(1);
			end else if (do_pop && !do_push) begin
				used_q <= used_q - NW'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/igfr_back.sv */
// Back end: runs queued read commands, reads the buffer one byte a cycle
// unless stalled; an output register drives the result stream. Uses igfr_pkg.
`default_nettype none

module igfr_back
	import igfr_pkg::*;
#(
	parameter int BUFFER_DEPTH = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       q_empty,
	input  wire cmd_t                       q_head,
	output logic                            q_pop,
	output logic                            frame_popped,
	output logic                            ram_re,
	output logic [$clog2(BUFFER_DEPTH)-1:0] ram_raddr,
	input  wire logic [7:0]                 ram_rdata,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [7:0]                      m_tdata,
	output logic [1:0]                      m_tuser,
	output logic                            m_tlast
);

	localparam int AW = $clog2(BUFFER_DEPTH);

	logic [AW-1:0] idx_q;
	logic          valid_s1;
	logic          has_s1;
	logic          last_s1;
	logic          drop_s1;
	logic          out_valid_q;
	logic          out_has_q;
	logic          out_last_q;
	logic          out_drop_q;
	logic [7:0]    out_byte_q;
	logic          s1_adv;
	logic          issue;
	logic          is_last;

	// The RAM read register is the stage-one data; it holds while stage one stalls.
	assign s1_adv  = valid_s1 && (!out_valid_q || m_tready);
	assign issue   = !q_empty && (!valid_s1 || s1_adv);
	assign is_last = !q_head.is_frame ||
		((MAX_CNT_W'(idx_q) + MAX_CNT_W'(1)) == q_head.count);

	assign ram_re       = issue && q_head.is_frame;
	assign ram_raddr    = idx_q;
	assign q_pop        = issue && is_last;
	assign frame_popped = q_pop && q_head.is_frame;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				idx_q <= is_last ? '0 : idx_q + AW'(1);
			end
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			has_s1  <= q_head.is_frame;
			last_s1 <= is_last;
			drop_s1 <= q_head.dropped;
		end
		if (s1_adv) begin
			out_has_q  <= has_s1;
			out_last_q <= last_s1;
			out_drop_q <= drop_s1;
			out_byte_q <= has_s1 ? ram_rdata : 8'd0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = {out_drop_q, out_has_q};
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

/* rtl/core/igfr_checker.sv */
// Port-level checks on the receiver's result stream, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module igfr_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic [1:0] m_tuser,
	input wire logic       m_tlast
);

	// A stalled result must not change.
	`CHK_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed while stalled")

	// A no-frame answer is a single zero result that ends its run.
	`CHK_ALWAYS(a_noframe_shape, !m_tvalid || m_tuser[0] || (m_tlast && (m_tdata == 8'd0) && !m_tuser[1]), "malformed no-frame result")

	// Frame bytes stream without gaps and keep the drop flag for the whole frame.
	`CHK_NEXT(a_frame_cont, m_tvalid && m_tready && m_tuser[0] && !m_tlast, m_tvalid && m_tuser[0] && $stable(m_tuser[1]), "frame stream broken")

endmodule

bind idle_gap_frame_receiver_unit igfr_checker u_igfr_checker (.*);

`default_nettype wire
